FILE: src/fhm_pkg.sv
// Shared constants, codes and types for the FIFO handoff mutex.
package fhm_pkg;

   // Fixed port widths
   localparam int MODE_BITS   = 2;
   localparam int REQ_BITS    = 8;
   localparam int STATUS_BITS = 3;
   localparam int ID_MAX_BITS = 16;

   // Parameter defaults
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_ID_BITS     = 8;

   // Request modes (the unused code behaves as a try lock)
   localparam logic [MODE_BITS-1:0] MODE_LOCK   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_TRY    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_UNLOCK = 2'd2;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] STAT_ACQUIRED    = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_QUEUED      = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_BUSY        = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_NO_WAIT     = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_FULL        = 3'd4;
   localparam logic [STATUS_BITS-1:0] STAT_RELEASED    = 3'd5;
   localparam logic [STATUS_BITS-1:0] STAT_UNLOCK_FREE = 3'd6;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture the request item
      logic exec;   // decide and update lock state
   } ctl_type;

endpackage

FILE: src/fhm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fhm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/fhm_ctrl.sv
// Controller: two-state sequencer that paces items through the datapath.
module fhm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output fhm_pkg::ctl_type   ctl
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      ctl.load = 1'b0;
      ctl.exec = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == S_EXEC);

endmodule

FILE: src/fhm_dpath.sv
// Datapath: lock flag, waiter queue pointers, waiter RAM and result registers.
module fhm_dpath #(
   parameter int QUEUE_DEPTH = fhm_pkg::DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = fhm_pkg::DEF_ID_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fhm_pkg::ctl_type                  ctl,
   input  logic [fhm_pkg::MODE_BITS-1:0]     req_mode,
   input  logic [fhm_pkg::REQ_BITS-1:0]      req_requester,
   input  logic                              req_can_wait,
   output logic                              rsp_strobe,
   output logic [fhm_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic                              rsp_wake_valid,
   output logic [fhm_pkg::REQ_BITS-1:0]      rsp_wake_requester
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   // captured request
   logic [fhm_pkg::MODE_BITS-1:0] mode_ff;
   logic [ID_BITS-1:0]            id_ff;
   logic                          can_wait_ff;
   logic [fhm_pkg::ID_MAX_BITS-1:0] req_wide;

   // lock state
   logic             held_ff,  held_in;
   logic [PTR_W-1:0] head_ff,  head_in;
   logic [PTR_W-1:0] tail_ff,  tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // results
   logic                            strobe_ff;
   logic [fhm_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic                            wake_ff,   wake_in;
   logic [fhm_pkg::REQ_BITS-1:0]    wake_id_ff, wake_id_in;

   logic                            push;
   logic [ID_BITS-1:0]              head_data;
   logic [fhm_pkg::ID_MAX_BITS-1:0] head_wide;

   assign req_wide  = fhm_pkg::ID_MAX_BITS'(req_requester);
   assign head_wide = fhm_pkg::ID_MAX_BITS'(head_data);

   // Read address tracks head; data is valid in the cycle after load.
   fhm_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_waiters (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (id_ff),
      .rd_addr (head_ff),
      .rd_data (head_data)
   );

   always_comb begin
      held_in    = held_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      push       = 1'b0;
      status_in  = status_ff;
      wake_in    = 1'b0;
      wake_id_in = '0;
      if (ctl.exec) begin
         case (mode_ff)
            fhm_pkg::MODE_LOCK: begin
               if (!held_ff) begin
                  held_in   = 1'b1;
                  status_in = fhm_pkg::STAT_ACQUIRED;
               end else if (!can_wait_ff) begin
                  status_in = fhm_pkg::STAT_NO_WAIT;
               end else if (count_ff >= FULL_CNT) begin
                  status_in = fhm_pkg::STAT_FULL;
               end else begin
                  push      = 1'b1;
                  tail_in   = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
                  count_in  = count_ff + 1'b1;
                  status_in = fhm_pkg::STAT_QUEUED;
               end
            end
            fhm_pkg::MODE_UNLOCK: begin
               if (!held_ff) begin
                  status_in = fhm_pkg::STAT_UNLOCK_FREE;
               end else if (count_ff != '0) begin
                  head_in    = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
                  count_in   = count_ff - 1'b1;
                  wake_in    = 1'b1;
                  wake_id_in = head_wide[fhm_pkg::REQ_BITS-1:0];
                  status_in  = fhm_pkg::STAT_RELEASED;
               end else begin
                  held_in   = 1'b0;
                  status_in = fhm_pkg::STAT_RELEASED;
               end
            end
            default: begin
               // try lock, and the unused mode code
               if (!held_ff) begin
                  held_in   = 1'b1;
                  status_in = fhm_pkg::STAT_ACQUIRED;
               end else begin
                  status_in = fhm_pkg::STAT_BUSY;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= 1'b0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         held_ff   <= held_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         strobe_ff <= ctl.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mode_ff     <= req_mode;
         id_ff       <= req_wide[ID_BITS-1:0];
         can_wait_ff <= req_can_wait;
      end
      if (ctl.exec) begin
         status_ff  <= status_in;
         wake_ff    <= wake_in;
         wake_id_ff <= wake_id_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_wake_valid     = wake_ff;
   assign rsp_wake_requester = wake_id_ff;

endmodule

FILE: src/fifo_handoff_mutex.sv
// Top level of the FIFO handoff mutex: controller, datapath and checks.
// An accepted item passes through the EXEC state; its result is then registered and strobed.
// A new item is not taken while busy; busy is high for the execute cycle, in which
// the waiter RAM's registered read of the queue head lands and the lock state updates.
// The result shows for one cycle on rsp_strobe; the receiver cannot stall it.
// Reset (synchronous, active high): lock free, queue empty, no strobe; the waiter
// RAM is not cleared, since an entry is only read after it was written.
module fifo_handoff_mutex #(
   parameter int QUEUE_DEPTH = fhm_pkg::DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = fhm_pkg::DEF_ID_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request item
   input  logic                              start,
   output logic                              busy,
   input  logic [fhm_pkg::MODE_BITS-1:0]     req_mode,
   input  logic [fhm_pkg::REQ_BITS-1:0]      req_requester,
   input  logic                              req_can_wait,
   // result item
   output logic                              rsp_strobe,
   output logic [fhm_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic                              rsp_wake_valid,
   output logic [fhm_pkg::REQ_BITS-1:0]      rsp_wake_requester
);

   fhm_pkg::ctl_type ctl;

   // Sequencer: IDLE takes an item (load), EXEC applies it (exec).
   fhm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl)
   );

   // Lock flag, circular waiter queue and result registers.
   fhm_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .req_mode           (req_mode),
      .req_requester      (req_requester),
      .req_can_wait       (req_can_wait),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_wake_valid     (rsp_wake_valid),
      .rsp_wake_requester (rsp_wake_requester)
   );

`ifndef SYNTH
   // An accepted item always moves into the execute cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // Every execute cycle is followed by exactly one result strobe.
   a_exec_strobe: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && !busy))
      else $error("execute cycle not followed by a result");

   // A wake only comes with a handoff release.
   a_wake_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_wake_valid) |-> (rsp_status == fhm_pkg::STAT_RELEASED))
      else $error("wake reported without release status");

   // Without a wake the reported id is zero.
   a_wake_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_wake_valid) |-> (rsp_wake_requester == '0))
      else $error("nonzero wake id without wake");
`endif

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the FIFO handoff mutex: directed corners, then random traffic.
module testbench;

   // DUT runs with its default sizes
   localparam int LOCK_DEPTH = fhm_pkg::DEF_QUEUE_DEPTH;
   localparam int ID_WIDTH   = fhm_pkg::DEF_ID_BITS;
   localparam logic [fhm_pkg::REQ_BITS-1:0] ID_MASK =
      fhm_pkg::REQ_BITS'((1 << ID_WIDTH) - 1);

   // Undefined mode code; the lock treats it as a try lock
   localparam logic [fhm_pkg::MODE_BITS-1:0] MODE_SPARE = 2'd3;

   localparam int RANDOM_ITEMS = 1925;
   localparam int IDLE_LIMIT   = 400;  // cycles with no item moving on either side
   localparam int DRAIN_CYCLES = 8;    // quiet time after the last result

   typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} traffic_bias_type;

   typedef struct {
      logic [fhm_pkg::STATUS_BITS-1:0] status;
      logic                            wake_valid;
      logic [fhm_pkg::REQ_BITS-1:0]    wake_requester;
   } grant_type;

   // Lock predictor plus in-order store of expected grants
   class lock_scoreboard;
      bit                           held;
      logic [fhm_pkg::REQ_BITS-1:0] waiters[$];
      grant_type                    outcomes[$];
      int                           failures = 0;

      function void note_request(logic [fhm_pkg::MODE_BITS-1:0] mode,
                                 logic [fhm_pkg::REQ_BITS-1:0] requester,
                                 logic can_wait);
         grant_type g;
         g.status         = fhm_pkg::STAT_ACQUIRED;
         g.wake_valid     = 1'b0;
         g.wake_requester = '0;
         case (mode)
            fhm_pkg::MODE_LOCK: begin
               if (!held) begin
                  held = 1'b1;
               end else if (!can_wait) begin
                  g.status = fhm_pkg::STAT_NO_WAIT;
               end else if (waiters.size() >= LOCK_DEPTH) begin
                  g.status = fhm_pkg::STAT_FULL;
               end else begin
                  waiters.push_back(requester & ID_MASK);
                  g.status = fhm_pkg::STAT_QUEUED;
               end
            end
            fhm_pkg::MODE_UNLOCK: begin
               // requester is ignored: ownership is not tracked
               if (!held) begin
                  g.status = fhm_pkg::STAT_UNLOCK_FREE;
               end else if (waiters.size() > 0) begin
                  g.status         = fhm_pkg::STAT_RELEASED;
                  g.wake_valid     = 1'b1;
                  g.wake_requester = waiters.pop_front();
               end else begin
                  held     = 1'b0;
                  g.status = fhm_pkg::STAT_RELEASED;
               end
            end
            default: begin
               // try lock, and the spare code
               if (!held) held = 1'b1;
               else g.status = fhm_pkg::STAT_BUSY;
            end
         endcase
         outcomes.push_back(g);
      endfunction

      function void check_grant(logic [fhm_pkg::STATUS_BITS-1:0] status,
                                logic wake_valid,
                                logic [fhm_pkg::REQ_BITS-1:0] wake_requester);
         grant_type g;
         if (outcomes.size() == 0) begin
            $error("result with no request outstanding: status %0d", status);
            failures++;
            return;
         end
         g = outcomes.pop_front();
         if (status !== g.status) begin
            $error("status: expected %0d, actual %0d", g.status, status);
            failures++;
         end
         if (wake_valid !== g.wake_valid) begin
            $error("wake_valid: expected %0d, actual %0d", g.wake_valid, wake_valid);
            failures++;
         end
         if (wake_requester !== g.wake_requester) begin
            $error("wake_requester: expected %0d, actual %0d",
                   g.wake_requester, wake_requester);
            failures++;
         end
      endfunction

      function int pending();
         return outcomes.size();
      endfunction
   endclass

   logic                            clock         = 1'b0;
   logic                            reset         = 1'b1;
   logic                            start         = 1'b0;
   logic [fhm_pkg::MODE_BITS-1:0]   req_mode      = fhm_pkg::MODE_LOCK;
   logic [fhm_pkg::REQ_BITS-1:0]    req_requester = '0;
   logic                            req_can_wait  = 1'b0;
   logic                            busy;
   logic                            rsp_strobe;
   logic [fhm_pkg::STATUS_BITS-1:0] rsp_status;
   logic                            rsp_wake_valid;
   logic [fhm_pkg::REQ_BITS-1:0]    rsp_wake_requester;

   lock_scoreboard sb = new;
   int idle_cycles = 0;

   fifo_handoff_mutex DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_requester      (req_requester),
      .req_can_wait       (req_can_wait),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_wake_valid     (rsp_wake_valid),
      .rsp_wake_requester (rsp_wake_requester)
   );

   always #2 clock = ~clock;

   // Monitor: everything sampled at the rising edge, pre-update values.
   // Results are checked before the new item is noted; an item never
   // answers at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1)
            sb.check_grant(rsp_status, rsp_wake_valid, rsp_wake_requester);
         if (start && busy === 1'b0)
            sb.note_request(req_mode, req_requester, req_can_wait);
      end
   end

   // Watchdog: any cycle that moves an item on either side resets the count
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_strobe === 1'b1) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL fifo_handoff_mutex");
         $finish;
      end
   end

   // One item: optional idle gap, then hold start until the block takes it.
   // With no gap start stays high straight into the next item.
   task automatic send_request(input logic [fhm_pkg::MODE_BITS-1:0] mode,
                               input logic [fhm_pkg::REQ_BITS-1:0] requester,
                               input logic can_wait, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode      <= mode;
      req_requester <= requester;
      req_can_wait  <= can_wait;
      start         <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   initial begin
      int                            items_left;
      int                            burst_len;
      int                            roll;
      int                            gap;
      bit                            quiet;
      traffic_bias_type              bias;
      logic [fhm_pkg::MODE_BITS-1:0] mode;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: free-lock unlock, spare code on free and held lock,
      // plain release, try lock both ways, refusal without wait, a full
      // queue of waiters (ids 0 to 255 in steps of 17), queue overflow, then a handoff.
      send_request(fhm_pkg::MODE_UNLOCK, 8'hA5, 1'b1, $urandom_range(0, 14));
      send_request(MODE_SPARE,           8'h00, 1'b0, $urandom_range(0, 14));
      send_request(fhm_pkg::MODE_UNLOCK, 8'h5A, 1'b0, $urandom_range(0, 14));
      send_request(fhm_pkg::MODE_TRY,    8'hFF, 1'b1, $urandom_range(0, 14));
      send_request(fhm_pkg::MODE_TRY,    8'h01, 1'b0, $urandom_range(0, 14));
      send_request(MODE_SPARE,           8'h80, 1'b1, $urandom_range(0, 14));
      send_request(fhm_pkg::MODE_LOCK,   8'h7F, 1'b0, $urandom_range(0, 14));
      for (int i = 0; i < LOCK_DEPTH; i++)
         send_request(fhm_pkg::MODE_LOCK, fhm_pkg::REQ_BITS'(i * 17), 1'b1,
                      $urandom_range(0, 14));
      send_request(fhm_pkg::MODE_LOCK,   8'hC3, 1'b1, $urandom_range(0, 14));
      send_request(fhm_pkg::MODE_UNLOCK, 8'h3C, 1'b1, $urandom_range(0, 14));

      // Random: bursts that fill the queue, drain it, or mix freely,
      // so both the full queue and the free lock come up again and again.
      // Some bursts run back to back with no idle cycles.
      items_left = RANDOM_ITEMS;
      while (items_left > 0) begin
         burst_len = $urandom_range(1, 40);
         bias      = traffic_bias_type'($urandom_range(0, 2));
         quiet     = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < burst_len && items_left > 0; k++) begin
            roll = $urandom_range(0, 99);
            case (bias)
               BIAS_FILL:
                  mode = roll < 70 ? fhm_pkg::MODE_LOCK :
                         roll < 80 ? fhm_pkg::MODE_TRY :
                         roll < 85 ? MODE_SPARE : fhm_pkg::MODE_UNLOCK;
               BIAS_DRAIN:
                  mode = roll < 65 ? fhm_pkg::MODE_UNLOCK :
                         roll < 85 ? fhm_pkg::MODE_LOCK :
                         roll < 95 ? fhm_pkg::MODE_TRY : MODE_SPARE;
               default:
                  mode = fhm_pkg::MODE_BITS'($urandom_range(0, 3));
            endcase
            gap = quiet ? 0 : $urandom_range(0, 14);
            send_request(mode, fhm_pkg::REQ_BITS'($urandom_range(0, 255)),
                         $urandom_range(0, 9) != 0, gap);
            items_left--;
         end
      end
      start <= 1'b0;

      // Let outstanding grants land, then watch for strays
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0) begin
         $display("PASS fifo_handoff_mutex");
      end else begin
         $display("FAIL fifo_handoff_mutex");
      end
      $finish;
   end

endmodule
